FILE: design/bilinear_image_scaler_defines.svh
// assertion macros for the bilinear scaler
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

`ifndef SYNTH
`define BIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bis assertion failed");
`define BIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bis assertion failed");
`else
`define BIS_ASSERT_IMP(lbl, ante, cons)
`define BIS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: design/bis_pkg.sv
package bis_pkg;

  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;
  localparam int unsigned FracBits  = 8;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned StepW    = 26;
  localparam int unsigned SizeW    = 10;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 26;
  localparam int unsigned QFrac    = 16;
  localparam int unsigned PosW     = CoordW + StepW;
  localparam int unsigned IntW     = PosW - QFrac;

  localparam logic [CfgIdxW-1:0] RegSrcWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSrcHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStepX     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStepY     = 3'd3;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [SizeW-1:0] SizeRst = 10'd512;
  localparam logic [StepW-1:0] StepRst = 26'd65536;

endpackage

FILE: design/bis_if.sv
interface bis_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [bis_pkg::CoordW-1:0]  coord_x;
  logic [bis_pkg::CoordW-1:0]  coord_y;
  logic [bis_pkg::PixW-1:0]    pixel_value;
  modport source (output valid, op, coord_x, coord_y, pixel_value, input ready);
  modport sink   (input valid, op, coord_x, coord_y, pixel_value, output ready);
endinterface

interface bis_out_if;
  logic                      valid;
  logic                      ready;
  logic [bis_pkg::PixW-1:0]  result_value;
  logic                      position_clamped;
  modport source (output valid, result_value, position_clamped, input ready);
  modport sink   (input valid, result_value, position_clamped, output ready);
endinterface

interface bis_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bis_pkg::CfgIdxW-1:0]   index;
  logic [bis_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/bis_ram.sv
module bis_ram #(
  parameter int unsigned WIDTH = bis_pkg::PixW,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bilinear_image_scaler.sv
// a query result passes through every stage to the output register, a stall holds it there
// throughput: one word per cycle while the output is not stalled, loads and queries mixed freely
// four parity banks of the frame store give all four neighbors in one read
// reset clears the pipeline valid bits and the configuration registers to their defaults
// frame store contents are undefined after reset, there is no clearing pass
`include "bilinear_image_scaler_defines.svh"

module bilinear_image_scaler #(
  parameter int unsigned MAX_WIDTH  = bis_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = bis_pkg::MaxHeight,
  parameter int unsigned FRAC_BITS  = bis_pkg::FracBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bis_in_if.sink    in_i,
  bis_out_if.source out_o,
  bis_cfg_if.sink   cfg_i
);

  localparam int unsigned CW        = $clog2(MAX_WIDTH);
  localparam int unsigned RW        = $clog2(MAX_HEIGHT);
  localparam int unsigned BAW       = CW + RW - 2;
  localparam int unsigned BankDepth = 2 ** BAW;
  localparam int unsigned WW        = FRAC_BITS + 1;
  localparam int unsigned WPW       = 2 * FRAC_BITS + 2;
  localparam int unsigned PPW       = WPW + bis_pkg::PixW;
  localparam int unsigned SW        = PPW + 2;
  localparam int unsigned PosW      = bis_pkg::PosW;
  localparam int unsigned IntW      = bis_pkg::IntW;
  localparam int unsigned QFrac     = bis_pkg::QFrac;
  localparam logic [WW-1:0] One     = WW'(1) << FRAC_BITS;

  // configuration registers
  logic [bis_pkg::SizeW-1:0] src_width_q, src_height_q;
  logic [bis_pkg::StepW-1:0] step_x_q, step_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bis_pkg::SizeRst;
      src_height_q <= bis_pkg::SizeRst;
      step_x_q     <= bis_pkg::StepRst;
      step_y_q     <= bis_pkg::StepRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        bis_pkg::RegSrcWidth:  src_width_q  <= cfg_i.data[bis_pkg::SizeW-1:0];
        bis_pkg::RegSrcHeight: src_height_q <= cfg_i.data[bis_pkg::SizeW-1:0];
        bis_pkg::RegStepX:     step_x_q     <= cfg_i.data[bis_pkg::StepW-1:0];
        bis_pkg::RegStepY:     step_y_q     <= cfg_i.data[bis_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // last valid column and row of the source frame
  logic [CW-1:0] last_x;
  logic [RW-1:0] last_y;

  always_comb begin
    if (src_width_q == '0) begin
      last_x = '0;
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      last_x = CW'(MAX_WIDTH - 1);
    end else begin
      last_x = CW'(src_width_q - 1'b1);
    end
    if (src_height_q == '0) begin
      last_y = '0;
    end else if (32'(src_height_q) > MAX_HEIGHT) begin
      last_y = RW'(MAX_HEIGHT - 1);
    end else begin
      last_y = RW'(src_height_q - 1'b1);
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;
  logic op2_q;

  assign r5 = !v5_q || out_o.ready;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_i.ready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q && (op2_q == bis_pkg::OpQuery);
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
    end
  end

  // stage 1: coordinate times step
  logic                       op1_q;
  logic [bis_pkg::CoordW-1:0] cx1_q, cy1_q;
  logic [bis_pkg::PixW-1:0]   px1_q;
  logic [PosW-1:0]            posx1_q, posy1_q;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && r1) begin
      op1_q   <= in_i.op;
      cx1_q   <= in_i.coord_x;
      cy1_q   <= in_i.coord_y;
      px1_q   <= in_i.pixel_value;
      posx1_q <= PosW'(in_i.coord_x) * PosW'(step_x_q);
      posy1_q <= PosW'(in_i.coord_y) * PosW'(step_y_q);
    end
  end

  // stage 2: integer part, fraction, saturation, far neighbor and load bank and address
  logic [IntW-1:0]      ipx, ipy;
  logic [CW-1:0]        ix, ix2;
  logic [RW-1:0]        iy, iy2;
  logic [FRAC_BITS-1:0] fx, fy;
  logic                 clx, cly, ld_ok;

  always_comb begin
    ipx = posx1_q[PosW-1:QFrac];
    ipy = posy1_q[PosW-1:QFrac];
    if (ipx > IntW'(last_x)) begin
      ix  = last_x;
      fx  = '0;
      clx = 1'b1;
    end else begin
      ix  = ipx[CW-1:0];
      fx  = posx1_q[QFrac-1 -: FRAC_BITS];
      clx = 1'b0;
    end
    if (ipy > IntW'(last_y)) begin
      iy  = last_y;
      fy  = '0;
      cly = 1'b1;
    end else begin
      iy  = ipy[RW-1:0];
      fy  = posy1_q[QFrac-1 -: FRAC_BITS];
      cly = 1'b0;
    end
    ix2   = (ix < last_x) ? ix + CW'(1) : ix;
    iy2   = (iy < last_y) ? iy + RW'(1) : iy;
    ld_ok = ({1'b0, cx1_q} < (bis_pkg::CoordW+1)'(MAX_WIDTH)) &&
            ({1'b0, cy1_q} < (bis_pkg::CoordW+1)'(MAX_HEIGHT));
  end

  logic                     clamp2_q, ld_ok2_q;
  logic [CW-1:0]            ixa_q, ixb_q;
  logic [RW-1:0]            iya_q, iyb_q;
  logic [FRAC_BITS-1:0]     fx2_q, fy2_q;
  logic [1:0]               ld_bank2_q;
  logic [BAW-1:0]           ld_addr2_q;
  logic [bis_pkg::PixW-1:0] px2_q;

  always_ff @(posedge clk_i) begin
    if (v1_q && r2) begin
      op2_q      <= op1_q;
      clamp2_q   <= clx || cly;
      ld_ok2_q   <= ld_ok;
      ixa_q      <= ix;
      ixb_q      <= ix2;
      iya_q      <= iy;
      iyb_q      <= iy2;
      fx2_q      <= fx;
      fy2_q      <= fy;
      ld_bank2_q <= {cy1_q[0], cx1_q[0]};
      ld_addr2_q <= {cy1_q[RW-1:1], cx1_q[CW-1:1]};
      px2_q      <= px1_q;
    end
  end

  // frame store: four banks by row and column parity, read and written here
  logic [bis_pkg::PixW-1:0] bank_rdata [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int unsigned RowPar = b / 2;
    localparam int unsigned ColPar = b % 2;
    logic [RW-1:0]  row;
    logic [CW-1:0]  col;
    logic [BAW-1:0] raddr;
    logic           we;

    assign row   = (iya_q[0] == 1'(RowPar)) ? iya_q : iyb_q;
    assign col   = (ixa_q[0] == 1'(ColPar)) ? ixa_q : ixb_q;
    assign raddr = {row[RW-1:1], col[CW-1:1]};
    assign we    = v2_q && (op2_q == bis_pkg::OpLoad) && ld_ok2_q &&
                   (ld_bank2_q == 2'(b)) && r3;

    bis_ram #(
      .WIDTH (bis_pkg::PixW),
      .DEPTH (BankDepth)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (ld_addr2_q),
      .wdata_i (px2_q),
      .re_i    (r3),
      .raddr_i (raddr),
      .rdata_o (bank_rdata[b])
    );
  end

  // stage 3: corner weights, bank data arrives with them
  logic [WPW-1:0] w00_q, w01_q, w10_q, w11_q;
  logic           pxa3_q, pxb3_q, pya3_q, pyb3_q, clamp3_q;
  logic [WW-1:0]  wx0, wx1, wy0, wy1;

  assign wx1 = {1'b0, fx2_q};
  assign wy1 = {1'b0, fy2_q};
  assign wx0 = One - wx1;
  assign wy0 = One - wy1;

  always_ff @(posedge clk_i) begin
    if (v2_q && r3) begin
      w00_q    <= WPW'(wy0) * WPW'(wx0);
      w01_q    <= WPW'(wy0) * WPW'(wx1);
      w10_q    <= WPW'(wy1) * WPW'(wx0);
      w11_q    <= WPW'(wy1) * WPW'(wx1);
      pxa3_q   <= ixa_q[0];
      pxb3_q   <= ixb_q[0];
      pya3_q   <= iya_q[0];
      pyb3_q   <= iyb_q[0];
      clamp3_q <= clamp2_q;
    end
  end

  // stage 4: weighted corner samples
  logic [bis_pkg::PixW-1:0] p00, p01, p10, p11;
  logic [PPW-1:0]           pp00_q, pp01_q, pp10_q, pp11_q;
  logic                     clamp4_q;

  assign p00 = bank_rdata[{pya3_q, pxa3_q}];
  assign p01 = bank_rdata[{pya3_q, pxb3_q}];
  assign p10 = bank_rdata[{pyb3_q, pxa3_q}];
  assign p11 = bank_rdata[{pyb3_q, pxb3_q}];

  always_ff @(posedge clk_i) begin
    if (v3_q && r4) begin
      pp00_q   <= PPW'(w00_q) * PPW'(p00);
      pp01_q   <= PPW'(w01_q) * PPW'(p01);
      pp10_q   <= PPW'(w10_q) * PPW'(p10);
      pp11_q   <= PPW'(w11_q) * PPW'(p11);
      clamp4_q <= clamp3_q;
    end
  end

  // stage 5: sum and output register
  logic [SW-1:0]            sum;
  logic [bis_pkg::PixW-1:0] res5_q;
  logic                     clamp5_q;

  assign sum = SW'(pp00_q) + SW'(pp01_q) + SW'(pp10_q) + SW'(pp11_q);

  always_ff @(posedge clk_i) begin
    if (v4_q && r5) begin
      res5_q   <= sum[2*FRAC_BITS +: bis_pkg::PixW];
      clamp5_q <= clamp4_q;
    end
  end

  assign out_o.valid            = v5_q;
  assign out_o.result_value     = res5_q;
  assign out_o.position_clamped = clamp5_q;

  `BIS_ASSERT_NXT(a_accept_fills_s1, in_i.valid && in_i.ready, v1_q)
  `BIS_ASSERT_NXT(a_load_no_result, v2_q && (op2_q == bis_pkg::OpLoad) && r3, !v3_q)
  `BIS_ASSERT_NXT(a_query_advances, v2_q && (op2_q == bis_pkg::OpQuery) && r3, v3_q)
  `BIS_ASSERT_IMP(a_ready_when_out_empty, !v1_q, in_i.ready)

endmodule
